// File: hw/rtl/rham_pkg.sv
// ----------------------------------------------------------------------------
// rham_pkg
// shared types, register indexes, field masks and the bcd decode helper
// ----------------------------------------------------------------------------
package rham_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_MINUTE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEST_MODE_HOURS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_ONE_HOURS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_TWO_HOURS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_THREE_HOURS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUSTOM_ENABLE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUSTOM_HOUR      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUSTOM_MINUTE    = 3'd7;

   localparam logic [1:0] MODE_TEST  = 2'd0;
   localparam logic [1:0] MODE_ONE   = 2'd1;
   localparam logic [1:0] MODE_TWO   = 2'd2;
   localparam logic [1:0] MODE_THREE = 2'd3;

   localparam logic [5:0]  RST_TRIGGER_MINUTE   = 6'd0;
   localparam logic [23:0] RST_TEST_MODE_HOURS  = 24'hFFFFFF;
   localparam logic [23:0] RST_MODE_ONE_HOURS   = 24'h808080;
   localparam logic [23:0] RST_MODE_TWO_HOURS   = 24'h400400;
   localparam logic [23:0] RST_MODE_THREE_HOURS = 24'h000400;
   localparam logic        RST_CUSTOM_ENABLE    = 1'b0;
   localparam logic [4:0]  RST_CUSTOM_HOUR      = 5'd12;
   localparam logic [5:0]  RST_CUSTOM_MINUTE    = 6'd58;

   localparam logic [7:0] MINUTE_MASK   = 8'h7F;
   localparam logic [7:0] HOUR24_MASK   = 8'h3F;
   localparam logic [7:0] HOUR12_MASK   = 8'h1F;
   localparam logic [7:0] DATE_MASK     = 8'h3F;
   localparam logic [7:0] MONTH_MASK    = 8'h1F;
   localparam logic [7:0] NOON          = 8'd12;
   localparam logic [7:0] HOURS_PER_DAY = 8'd24;
   localparam int         BIT_12H       = 6;
   localparam int         BIT_PM        = 5;

   typedef struct packed {
      logic [5:0]  trigger_minute;
      logic [23:0] test_mode_hours;
      logic [23:0] mode_one_hours;
      logic [23:0] mode_two_hours;
      logic [23:0] mode_three_hours;
      logic        custom_enable;
      logic [4:0]  custom_hour;
      logic [5:0]  custom_minute;
   } cfg_type;

   typedef struct packed {
      logic       read_ok;
      logic [1:0] mode;
      logic [7:0] minute_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] date_bcd;
      logic [7:0] month_bcd;
      logic [7:0] year_bcd;
   } req_item_type;

   typedef struct packed {
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] date;
      logic [7:0] month;
      logic [7:0] year;
   } time_type;

   typedef struct packed {
      logic fire;
      logic fault;
   } stamp_status_type;

   // tens * 10 + ones, digits not checked
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'd0, b[7:4]};
      return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
   endfunction

endpackage

// File: hw/rtl/rham_if.sv
// ----------------------------------------------------------------------------
// rham interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface rham_req_if;
   import rham_pkg::*;
   logic       valid;
   logic       ready;
   logic       read_ok;
   logic [1:0] mode;
   logic [7:0] minute_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] date_bcd;
   logic [7:0] month_bcd;
   logic [7:0] year_bcd;
   modport source (output valid, read_ok, mode, minute_bcd, hour_bcd, date_bcd,
                   month_bcd, year_bcd, input ready);
   modport sink   (input valid, read_ok, mode, minute_bcd, hour_bcd, date_bcd,
                   month_bcd, year_bcd, output ready);
endinterface

interface rham_rsp_if;
   logic       valid;
   logic       ready;
   logic       fire;
   logic       fault;
   logic [7:0] hour_now;
   logic [7:0] minute_now;
   modport source (output valid, fire, fault, hour_now, minute_now, input ready);
   modport sink   (input valid, fire, fault, hour_now, minute_now, output ready);
endinterface

interface rham_csr_if;
   import rham_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rtc_hourly_alarm_matcher_unit.sv
// ----------------------------------------------------------------------------
// rtc_hourly_alarm_matcher_unit
// Takes one raw clock reading per transfer and returns one result per
// reading, in order. Readings are decoded from bcd (12-hour readings turned
// into 24-hour form) and checked against the minute and the hour mask of the
// selected mode, or against the custom hour and minute when that is enabled.
// fire is set once per matching minute: a stored timestamp of the last
// trigger suppresses repeats. A failed read latches fault, which stops all
// later triggers until reset; such a reading reports hour and minute as 0.
// A reading is taken every cycle while results are accepted; it passes the
// input register, decode, schedule check, timestamp compare and update, and
// the result register. Write registers only while idle; not enforced.
// ----------------------------------------------------------------------------
module rtc_hourly_alarm_matcher_unit (
   input  logic        clock,
   input  logic        reset,
   rham_req_if.sink    req_bus,
   rham_rsp_if.source  rsp_bus,
   rham_csr_if.sink    csr_bus
);
   import rham_pkg::*;

   cfg_type          cfg;
   time_type         now;
   logic             match;
   stamp_status_type status;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic         out_fire_ff;
   logic         out_fault_ff;
   logic [7:0]   out_hour_ff;
   logic [7:0]   out_minute_ff;
   logic         advance;
   logic         step;
   logic         req_xfer;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign step          = in_valid_ff && advance;
   assign in_valid_in   = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in  = step || (out_valid_ff && !rsp_bus.ready);

   rham_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rham_decode u_decode (
      .item (in_item_ff),
      .now  (now)
   );

   rham_sched u_sched (
      .cfg   (cfg),
      .mode  (in_item_ff.mode),
      .now   (now),
      .match (match)
   );

   rham_stamp u_stamp (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .read_ok (in_item_ff.read_ok),
      .match   (match),
      .now     (now),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.read_ok    <= req_bus.read_ok;
         in_item_ff.mode       <= req_bus.mode;
         in_item_ff.minute_bcd <= req_bus.minute_bcd;
         in_item_ff.hour_bcd   <= req_bus.hour_bcd;
         in_item_ff.date_bcd   <= req_bus.date_bcd;
         in_item_ff.month_bcd  <= req_bus.month_bcd;
         in_item_ff.year_bcd   <= req_bus.year_bcd;
      end
      if (step) begin
         out_fire_ff   <= status.fire;
         out_fault_ff  <= status.fault;
         out_hour_ff   <= in_item_ff.read_ok ? now.hour : 8'd0;
         out_minute_ff <= in_item_ff.read_ok ? now.minute : 8'd0;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.fire       = out_fire_ff;
   assign rsp_bus.fault      = out_fault_ff;
   assign rsp_bus.hour_now   = out_hour_ff;
   assign rsp_bus.minute_now = out_minute_ff;

endmodule

// File: hw/rtl/rham_csr.sv
// ----------------------------------------------------------------------------
// rham_csr
// schedule configuration registers, written through the register channel
// ----------------------------------------------------------------------------
module rham_csr (
   input  logic              clock,
   input  logic              reset,
   rham_csr_if.sink          csr_bus,
   output rham_pkg::cfg_type cfg
);
   import rham_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_bus.ready = 1'b1;
   assign write         = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_bus.index)
            CSR_TRIGGER_MINUTE:   cfg_in.trigger_minute   = csr_bus.data[5:0];
            CSR_TEST_MODE_HOURS:  cfg_in.test_mode_hours  = csr_bus.data;
            CSR_MODE_ONE_HOURS:   cfg_in.mode_one_hours   = csr_bus.data;
            CSR_MODE_TWO_HOURS:   cfg_in.mode_two_hours   = csr_bus.data;
            CSR_MODE_THREE_HOURS: cfg_in.mode_three_hours = csr_bus.data;
            CSR_CUSTOM_ENABLE:    cfg_in.custom_enable    = csr_bus.data[0];
            CSR_CUSTOM_HOUR:      cfg_in.custom_hour      = csr_bus.data[4:0];
            CSR_CUSTOM_MINUTE:    cfg_in.custom_minute    = csr_bus.data[5:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_minute   <= RST_TRIGGER_MINUTE;
         cfg_ff.test_mode_hours  <= RST_TEST_MODE_HOURS;
         cfg_ff.mode_one_hours   <= RST_MODE_ONE_HOURS;
         cfg_ff.mode_two_hours   <= RST_MODE_TWO_HOURS;
         cfg_ff.mode_three_hours <= RST_MODE_THREE_HOURS;
         cfg_ff.custom_enable    <= RST_CUSTOM_ENABLE;
         cfg_ff.custom_hour      <= RST_CUSTOM_HOUR;
         cfg_ff.custom_minute    <= RST_CUSTOM_MINUTE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/rham_decode.sv
// ----------------------------------------------------------------------------
// rham_decode
// masks the raw clock registers and decodes them from bcd, 12h to 24h hour
// ----------------------------------------------------------------------------
module rham_decode (
   input  rham_pkg::req_item_type item,
   output rham_pkg::time_type     now
);
   import rham_pkg::*;

   logic [7:0] hour12;
   logic [7:0] hour;

   always_comb begin
      hour12 = bcd_value(item.hour_bcd & HOUR12_MASK);
      if (item.hour_bcd[BIT_12H]) begin
         if (item.hour_bcd[BIT_PM]) begin
            hour = (hour12 == NOON) ? hour12 : hour12 + NOON;
         end else begin
            hour = (hour12 == NOON) ? 8'd0 : hour12;
         end
      end else begin
         hour = bcd_value(item.hour_bcd & HOUR24_MASK);
      end
   end

   assign now.hour   = hour;
   assign now.minute = bcd_value(item.minute_bcd & MINUTE_MASK);
   assign now.date   = bcd_value(item.date_bcd & DATE_MASK);
   assign now.month  = bcd_value(item.month_bcd & MONTH_MASK);
   assign now.year   = bcd_value(item.year_bcd);

endmodule

// File: hw/rtl/rham_sched.sv
// ----------------------------------------------------------------------------
// rham_sched
// schedule check: custom hour and minute, or minute plus mode hour mask
// ----------------------------------------------------------------------------
module rham_sched (
   input  rham_pkg::cfg_type  cfg,
   input  logic [1:0]         mode,
   input  rham_pkg::time_type now,
   output logic               match
);
   import rham_pkg::*;

   logic [23:0] hour_mask;
   logic        hour_hit;

   always_comb begin
      case (mode)
         MODE_TEST:  hour_mask = cfg.test_mode_hours;
         MODE_ONE:   hour_mask = cfg.mode_one_hours;
         MODE_TWO:   hour_mask = cfg.mode_two_hours;
         MODE_THREE: hour_mask = cfg.mode_three_hours;
         default:    hour_mask = cfg.test_mode_hours;
      endcase
   end

   assign hour_hit = (now.hour < HOURS_PER_DAY) && hour_mask[now.hour[4:0]];

   always_comb begin
      if (cfg.custom_enable) begin
         match = (now.hour == {3'd0, cfg.custom_hour}) &&
                 (now.minute == {2'd0, cfg.custom_minute});
      end else begin
         match = (now.minute == {2'd0, cfg.trigger_minute}) && hour_hit;
      end
   end

endmodule

// File: hw/rtl/rham_stamp.sv
// ----------------------------------------------------------------------------
// rham_stamp
// last trigger timestamp, repeat suppression and sticky read fault
// ----------------------------------------------------------------------------
module rham_stamp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       read_ok,
   input  logic                       match,
   input  rham_pkg::time_type         now,
   output rham_pkg::stamp_status_type status
);
   import rham_pkg::*;

   logic     stamp_valid_ff;
   logic     stamp_valid_in;
   time_type stamp_ff;
   time_type stamp_in;
   logic     fault_ff;
   logic     fault_in;
   logic     repeat_hit;
   logic     fire;

   assign repeat_hit = stamp_valid_ff && (now == stamp_ff);
   assign fire       = read_ok && match && !fault_ff && !repeat_hit;

   always_comb begin
      stamp_valid_in = stamp_valid_ff;
      stamp_in       = stamp_ff;
      fault_in       = fault_ff;
      if (step) begin
         if (!read_ok) begin
            fault_in = 1'b1;
         end
         if (fire) begin
            stamp_valid_in = 1'b1;
            stamp_in       = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_valid_ff <= 1'b0;
         fault_ff       <= 1'b0;
      end else begin
         stamp_valid_ff <= stamp_valid_in;
         fault_ff       <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
   end

   assign status.fire  = fire;
   assign status.fault = fault_ff || !read_ok;

endmodule
